### src/acf_pkg.sv
// Shared types and fixed-point constants for the complementary attitude filter.
package acf_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 19;
  localparam int ALPHA_W    = 17;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * ANGLE_W;

  // Datapath widths inside an axis lane.
  localparam int PRED_W  = 20;
  localparam int ACC_Q_W = 21;
  localparam int DIFF_W  = 22;
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MAG_W   = 32;

  // Shift amounts of the three scalings.
  localparam int INC_SHIFT   = 12;
  localparam int ACC_SHIFT   = 8;
  localparam int BLEND_SHIFT = 16;

  // Coefficients: dt = 0.01 and 0.1, both in Q0.16.
  localparam logic signed [MUL_B_W-1:0] DT_COEF    = 18'sd655;
  localparam logic signed [MUL_B_W-1:0] TENTH_COEF = 18'sd6554;

  // Rounding offsets (half an output LSB) for each scaling.
  localparam logic signed [PROD_W-1:0] RND_INC   = 38'sd2048;
  localparam logic signed [PROD_W-1:0] RND_ACC   = 38'sd128;
  localparam logic signed [PROD_W-1:0] RND_BLEND = 38'sd32768;

  // Gate bounds on the squared acceleration magnitude, Q16.16.
  localparam logic [MAG_W-1:0] GATE_LO = 32'd4194304;
  localparam logic [MAG_W-1:0] GATE_HI = 32'd9437184;

  // Angle wrap limits, LSB 2^-16 rad.
  localparam logic signed [PRED_W-1:0] PI_Q     = 20'sd205887;
  localparam logic signed [PRED_W-1:0] NEG_PI_Q = -20'sd205887;
  localparam logic signed [PRED_W-1:0] TWO_PI_Q = 20'sd411774;

  // Blend weight: unity and reset value.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd64225;

  // One classified sample waiting for the update unit.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
    logic signed [SAMPLE_W-1:0] rate_z;
    logic                       used;
  } acf_entry_t;

  // Step strobes from the update sequencer to the axis lanes.
  typedef struct packed {
    logic mul_inc;
    logic mul_acc;
    logic diff;
    logic mul_blend;
    logic commit;
  } acf_lane_ctl_t;

endpackage

### src/acf_front.sv
// Input stage: takes one sample, squares the accelerations on one multiplier and gates them.
module acf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [acf_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          push,
  output acf_pkg::acf_entry_t           push_entry,
  input  logic                          full
);
  import acf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_PUSH
  } front_state_t;

  front_state_t            state_r;
  logic [IN_DATA_W-1:0]    sample_r;
  logic [MAG_W-1:0]        mag_r;
  logic signed [SAMPLE_W-1:0] ax, ay, az;
  logic signed [SAMPLE_W-1:0] sq_sel;
  logic signed [2*SAMPLE_W-1:0] sq_s;
  logic [MAG_W-1:0]        sq;
  logic                    gate_pass;

  // Field slices of the held sample.
  assign ax = signed'(sample_r[15:0]);
  assign ay = signed'(sample_r[31:16]);
  assign az = signed'(sample_r[47:32]);

  // One squarer shared over the three axes.
  always_comb begin
    case (state_r)
      ST_SQX:  sq_sel = ax;
      ST_SQY:  sq_sel = ay;
      default: sq_sel = az;
    endcase
  end

  assign sq_s = sq_sel * sq_sel;
  assign sq   = unsigned'(sq_s);

  // Both bounds are exclusive.
  assign gate_pass = (mag_r > GATE_LO) && (mag_r < GATE_HI);

  assign in_tready = (state_r == ST_IDLE);
  // The item is handed over only when the queue has room for it.
  assign push      = (state_r == ST_PUSH) && !full;

  always_comb begin
    push_entry.accel_x = ax;
    push_entry.accel_y = ay;
    push_entry.rate_x  = signed'(sample_r[63:48]);
    push_entry.rate_y  = signed'(sample_r[79:64]);
    push_entry.rate_z  = signed'(sample_r[95:80]);
    push_entry.used    = gate_pass;
  end

  // Sequencer: accept, three squaring steps, then hand the item to the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata;
            state_r  <= ST_SQX;
          end
        end
        ST_SQX: begin
          mag_r   <= sq;
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          mag_r   <= mag_r + sq;
          state_r <= ST_SQZ;
        end
        ST_SQZ: begin
          mag_r   <= mag_r + sq;
          state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/acf_queue.sv
// Small FIFO of classified samples between the input stage and the update unit.
module acf_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acf_pkg::acf_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output acf_pkg::acf_entry_t head,
  output logic                valid
);
  import acf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  acf_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // The input stage never pushes into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### src/acf_axis.sv
// One angle lane: gyro increment, accelerometer angle, blend and wrap on one multiplier.
module acf_axis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  acf_pkg::acf_lane_ctl_t               ctl,
  input  logic signed [acf_pkg::SAMPLE_W-1:0]  rate,
  input  logic signed [acf_pkg::SAMPLE_W:0]    accel_term,
  input  logic [acf_pkg::ALPHA_W-1:0]          alpha,
  input  logic                                 used,
  output logic signed [acf_pkg::ANGLE_W-1:0]   angle,
  output logic signed [acf_pkg::ANGLE_W-1:0]   angle_nxt
);
  import acf_pkg::*;

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PRED_W-1:0]  pred_r;
  logic signed [ACC_Q_W-1:0] acc_r;
  logic signed [PRED_W-1:0]  diff_r;
  logic signed [ANGLE_W-1:0] angle_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  inc_sh, acc_sh, blend_sh;
  logic signed [PRED_W-1:0]  pred_nxt;
  logic signed [ACC_Q_W-1:0] acc_nxt;
  logic signed [DIFF_W-1:0]  diff_full;
  logic signed [PRED_W-1:0]  blended, merged, wrapped;

  // Operand selection for the shared multiplier.
  always_comb begin
    if (ctl.mul_inc) begin
      mul_a = MUL_A_W'(rate);
      mul_b = DT_COEF;
    end else if (ctl.mul_acc) begin
      mul_a = MUL_A_W'(accel_term);
      mul_b = TENTH_COEF;
    end else begin
      mul_a = diff_r;
      mul_b = signed'({1'b0, alpha});
    end
  end

  assign prod = mul_a * mul_b;

  // Rounded scalings of the registered product.
  assign inc_sh   = (prod_r + RND_INC) >>> INC_SHIFT;
  assign acc_sh   = (prod_r + RND_ACC) >>> ACC_SHIFT;
  assign blend_sh = (prod_r + RND_BLEND) >>> BLEND_SHIFT;

  // Gyro prediction and distance to the accelerometer angle.
  assign pred_nxt  = PRED_W'(angle_r) + PRED_W'(inc_sh);
  assign acc_nxt   = ACC_Q_W'(acc_sh);
  assign diff_full = DIFF_W'(pred_r) - DIFF_W'(acc_nxt);

  // The blend is acc + alpha * (pred - acc), which equals the weighted sum exactly.
  assign blended = PRED_W'(acc_r) + PRED_W'(blend_sh);
  assign merged  = used ? blended : pred_r;

  // Wrap once into plus or minus pi.
  always_comb begin
    if (merged > PI_Q) begin
      wrapped = merged - TWO_PI_Q;
    end else if (merged < NEG_PI_Q) begin
      wrapped = merged + TWO_PI_Q;
    end else begin
      wrapped = merged;
    end
  end

  assign angle_nxt = ANGLE_W'(wrapped);
  assign angle     = angle_r;

  // Angle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (ctl.commit) begin
      angle_r <= angle_nxt;
    end
  end

  // Working registers of the lane.
  always_ff @(posedge clk) begin
    if (ctl.mul_inc || ctl.mul_acc || ctl.mul_blend) begin
      prod_r <= prod;
    end
    if (ctl.mul_acc) begin
      pred_r <= pred_nxt;
    end
    if (ctl.diff) begin
      acc_r  <= acc_nxt;
      diff_r <= PRED_W'(diff_full);
    end
  end

endmodule

### src/acf_back.sv
// Update unit: steps three angle lanes through one sample and holds the result register.
module acf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  acf_pkg::acf_entry_t            q_entry,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic [acf_pkg::ALPHA_W-1:0]    blend_weight,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acf_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser
);
  import acf_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_INC,
    ST_ACC,
    ST_DIFF,
    ST_BLEND,
    ST_COMMIT
  } back_state_t;

  back_state_t               state_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;
  logic                      out_tuser_r;
  acf_lane_ctl_t             ctl;
  logic                      out_free;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [SAMPLE_W:0]  roll_term, pitch_term;
  logic signed [ANGLE_W-1:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [ANGLE_W-1:0] roll_nxt, pitch_nxt, yaw_nxt;

  assign out_free = !out_valid_r || out_tready;

  // Weights above one act as one.
  assign alpha = (blend_weight > ALPHA_ONE) ? ALPHA_ONE : blend_weight;

  // Small-angle accelerometer terms: roll from ay, pitch from -ax.
  assign roll_term  = (SAMPLE_W + 1)'(q_entry.accel_y);
  assign pitch_term = -((SAMPLE_W + 1)'(q_entry.accel_x));

  // Step strobes decoded from the sequencer state.
  always_comb begin
    ctl.mul_inc   = (state_r == ST_INC);
    ctl.mul_acc   = (state_r == ST_ACC);
    ctl.diff      = (state_r == ST_DIFF);
    ctl.mul_blend = (state_r == ST_BLEND);
    ctl.commit    = (state_r == ST_COMMIT) && out_free;
  end

  assign q_pop = ctl.commit;

  acf_axis u_roll (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rate       (q_entry.rate_x),
    .accel_term (roll_term),
    .alpha      (alpha),
    .used       (q_entry.used),
    .angle      (roll_angle),
    .angle_nxt  (roll_nxt)
  );

  acf_axis u_pitch (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rate       (q_entry.rate_y),
    .accel_term (pitch_term),
    .alpha      (alpha),
    .used       (q_entry.used),
    .angle      (pitch_angle),
    .angle_nxt  (pitch_nxt)
  );

  // Yaw follows the gyro alone.
  acf_axis u_yaw (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rate       (q_entry.rate_z),
    .accel_term ('0),
    .alpha      (alpha),
    .used       (1'b0),
    .angle      (yaw_angle),
    .angle_nxt  (yaw_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      // A commit fills the result register; otherwise a taken result empties it.
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_WAIT: begin
          if (q_valid) begin
            state_r <= ST_INC;
          end
        end
        ST_INC:   state_r <= ST_ACC;
        ST_ACC:   state_r <= ST_DIFF;
        ST_DIFF:  state_r <= ST_BLEND;
        ST_BLEND: state_r <= ST_COMMIT;
        ST_COMMIT: begin
          if (out_free) begin
            out_tdata_r <= {{OUT_PAD_W{1'b0}}, yaw_nxt, pitch_nxt, roll_nxt};
            out_tuser_r <= q_entry.used;
            state_r     <= ST_WAIT;
          end
        end
        default: state_r <= ST_WAIT;
      endcase
    end
  end

  // A sample is only released from the queue when one is there.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // Angles move only at a commit.
  assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.commit |=> ($stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle)))
    else $error("angle changed without commit");

  // Every commit offers a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) ctl.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

### src/imu_complementary_attitude_filter_unit.sv
// Top level of the IMU complementary attitude filter.
// Each input item is one IMU sample and yields exactly one result item with the updated
// roll, pitch and yaw angles. The input stage takes a sample, squares the three
// accelerations on a single multiplier and classifies it against the gate before it
// takes the next sample; a queue of QUEUE_DEPTH samples then feeds the update unit, in
// which each axis has one multiplier used for the gyro increment, the accelerometer angle
// and the blend. The update unit steps each sample through the increment, accelerometer,
// difference, blend and commit steps and takes no new sample before the commit. The
// result register lets the next sample proceed while a result waits to be taken. The
// user must write the blend weight through cfg_wr_en/cfg_wr_data only while the block is
// idle; the block itself does not enforce this. Values above 65536 act as 65536.
module imu_complementary_attitude_filter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, lowest first)
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acf_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: roll_out, pitch_out, yaw_out (19 bits each, lowest first), zero padded
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acf_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: accel_used
  output logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [acf_pkg::ALPHA_W-1:0]    cfg_wr_data
);
  import acf_pkg::*;

  logic [ALPHA_W-1:0] blend_weight_r;
  logic               push, full, pop, q_valid;
  acf_entry_t         push_entry, q_head;

  // Blend weight register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      blend_weight_r <= cfg_wr_data;
    end
  end

  acf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  acf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (q_head),
    .valid      (q_valid)
  );

  acf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_entry      (q_head),
    .q_valid      (q_valid),
    .q_pop        (pop),
    .blend_weight (blend_weight_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

### test/imu_complementary_attitude_filter_unit_tb.sv
// Self-checking testbench for the IMU complementary attitude filter, with its own predictor.
module imu_complementary_attitude_filter_unit_tb;
  import acf_pkg::*;

  // Fixed-point constants of the filter arithmetic.
  localparam longint DT_Q16          = 655;
  localparam longint TENTH_Q16       = 6554;
  localparam longint GATE_LO_MAG     = 4194304;
  localparam longint GATE_HI_MAG     = 9437184;
  localparam longint PI_ANGLE        = 205887;
  localparam longint TWO_PI_ANGLE    = 411774;
  localparam longint UNITY_WEIGHT    = 65536;
  localparam longint WEIGHT_AT_RESET = 64225;

  // Run shape.
  localparam int PHASES             = 7;
  localparam int PHASE_ITEMS        = 210;
  localparam int SPIN_ITEMS         = 60;
  localparam int STALL_LIMIT        = 5000;
  localparam int HOLD_CYCLES        = 300;
  localparam int HOLD_AFTER_RESULTS = 400;
  localparam int MAX_REPORTS        = 200;
  localparam int DRAIN_CYCLES       = 30;

  // One IMU sample, packed so that accel_x lands in the lowest bits of in_tdata.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] rate_z;
    logic signed [SAMPLE_W-1:0] rate_y;
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_x;
  } imu_sample_t;

  // One predicted attitude result.
  typedef struct packed {
    logic               used;
    logic [ANGLE_W-1:0] yaw;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] roll;
  } attitude_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en;
  logic [ALPHA_W-1:0]    cfg_wr_data;

  imu_sample_t sample_backlog[$];
  attitude_t   attitude_due[$];

  // Predictor state: the three angles and the gyro weight.
  longint      est_roll;
  longint      est_pitch;
  longint      est_yaw;
  longint      gyro_weight;

  int          in_idle_pct;
  int          out_idle_pct;
  int          results_seen;
  int          hold_left;
  logic        hold_done;
  int          quiet_cycles;
  int          errors;

  imu_complementary_attitude_filter_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Wrap an angle once by a full turn when it lies beyond plus or minus pi.
  function automatic longint wrap_half_turn(longint angle);
    if (angle > PI_ANGLE) return angle - TWO_PI_ANGLE;
    if (angle < -PI_ANGLE) return angle + TWO_PI_ANGLE;
    return angle;
  endfunction

  // Advance the predicted attitude by one sample and return the result it yields.
  function automatic attitude_t advance_attitude(imu_sample_t s);
    longint    ax, ay, az, gx, gy, gz;
    longint    pred_r, pred_p, pred_y, mag, a, acc_r, acc_p, nr, np;
    logic      used;
    attitude_t res;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    gx = s.rate_x;
    gy = s.rate_y;
    gz = s.rate_z;
    pred_r = est_roll + ((gx * DT_Q16 + 2048) >>> 12);
    pred_p = est_pitch + ((gy * DT_Q16 + 2048) >>> 12);
    pred_y = est_yaw + ((gz * DT_Q16 + 2048) >>> 12);
    mag = ax * ax + ay * ay + az * az;
    used = (mag > GATE_LO_MAG) && (mag < GATE_HI_MAG);
    if (used) begin
      a = (gyro_weight > UNITY_WEIGHT) ? UNITY_WEIGHT : gyro_weight;
      acc_r = (ay * TENTH_Q16 + 128) >>> 8;
      acc_p = (-ax * TENTH_Q16 + 128) >>> 8;
      nr = (a * pred_r + (UNITY_WEIGHT - a) * acc_r + 32768) >>> 16;
      np = (a * pred_p + (UNITY_WEIGHT - a) * acc_p + 32768) >>> 16;
    end else begin
      nr = pred_r;
      np = pred_p;
    end
    est_roll = wrap_half_turn(nr);
    est_pitch = wrap_half_turn(np);
    est_yaw = wrap_half_turn(pred_y);
    res.roll = est_roll[ANGLE_W-1:0];
    res.pitch = est_pitch[ANGLE_W-1:0];
    res.yaw = est_yaw[ANGLE_W-1:0];
    res.used = used;
    return res;
  endfunction

  task automatic push_sample(int ax, int ay, int az, int gx, int gy, int gz);
    imu_sample_t s;
    s.accel_x = SAMPLE_W'(ax);
    s.accel_y = SAMPLE_W'(ay);
    s.accel_z = SAMPLE_W'(az);
    s.rate_x = SAMPLE_W'(gx);
    s.rate_y = SAMPLE_W'(gy);
    s.rate_z = SAMPLE_W'(gz);
    sample_backlog.push_back(s);
  endtask

  function automatic int random_sign();
    return ($urandom_range(1) != 0) ? 1 : -1;
  endfunction

  // Random samples: mostly gravity-like accelerations, some on the gate bounds,
  // some wholly random, with one run of large rates of fixed sign so the angles wrap.
  task automatic queue_random_samples(int n);
    int ax, ay, az, gx, gy, gz, kind, spin_at, axis, mag;
    int dir_x, dir_y, dir_z;
    spin_at = $urandom_range(n - SPIN_ITEMS);
    dir_x = random_sign();
    dir_y = random_sign();
    dir_z = random_sign();
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        ax = $urandom_range(2400) - 1200;
        ay = $urandom_range(2400) - 1200;
        az = random_sign() * $urandom_range(2700, 1900);
      end else if (kind < 75) begin
        ax = 0;
        ay = 0;
        az = 0;
        case ($urandom_range(5))
          0: mag = 2047;
          1: mag = 2048;
          2: mag = 2049;
          3: mag = 3071;
          4: mag = 3072;
          default: mag = 3073;
        endcase
        axis = $urandom_range(2);
        if (axis == 0) ax = random_sign() * mag;
        else if (axis == 1) ay = random_sign() * mag;
        else az = random_sign() * mag;
      end else begin
        ax = $urandom_range(65535);
        ay = $urandom_range(65535);
        az = $urandom_range(65535);
      end
      if (i >= spin_at && i < spin_at + SPIN_ITEMS) begin
        gx = dir_x * $urandom_range(32767, 28000);
        gy = dir_y * $urandom_range(32767, 28000);
        gz = dir_z * $urandom_range(32767, 28000);
      end else if ($urandom_range(99) < 70) begin
        gx = $urandom_range(4000) - 2000;
        gy = $urandom_range(4000) - 2000;
        gz = $urandom_range(4000) - 2000;
      end else begin
        gx = $urandom_range(65535);
        gy = $urandom_range(65535);
        gz = $urandom_range(65535);
      end
      push_sample(ax, ay, az, gx, gy, gz);
    end
  endtask

  // Wait until no sample is offered or queued and every result has arrived.
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_tvalid || attitude_due.size() != 0);
  endtask

  // Write the gyro weight while the block is idle.
  task automatic load_gyro_weight(int unsigned w);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w[ALPHA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gyro_weight = w & 32'h1FFFF;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Input driver: offers queued samples and records the prediction for each accepted one.
  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) attitude_due.push_back(advance_attitude(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= sample_backlog.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result checker: each accepted item against the oldest prediction.
  always @(posedge clk) begin : result_checker
    attitude_t want;
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (attitude_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result item arrived with no sample waiting");
      end else begin
        want = attitude_due.pop_front();
        check_field("roll_out", $signed(want.roll), $signed(out_tdata[ANGLE_W-1:0]));
        check_field("pitch_out", $signed(want.pitch),
                    $signed(out_tdata[2*ANGLE_W-1:ANGLE_W]));
        check_field("yaw_out", $signed(want.yaw), $signed(out_tdata[3*ANGLE_W-1:2*ANGLE_W]));
        check_field("accel_used", want.used, out_tuser);
        check_field("tdata padding", 0, out_tdata[OUT_DATA_W-1:3*ANGLE_W]);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin : stall_watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus sequence: directed samples, then one random phase per gyro weight.
  initial begin
    int unsigned phase_weight[PHASES];
    int unsigned w;
    phase_weight = '{0, 65536, 131071, 65537, 0, 32768, 64225};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_idle_pct = 33;
    out_idle_pct = 33;
    quiet_cycles = 0;
    errors = 0;
    est_roll = 0;
    est_pitch = 0;
    est_yaw = 0;
    gyro_weight = WEIGHT_AT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset weight: field extremes and both gate bounds.
    push_sample(0, 0, 0, 0, 0, 0);
    push_sample(0, 0, 0, 32767, 32767, 32767);
    push_sample(0, 0, 0, -32768, -32768, -32768);
    push_sample(32767, 32767, 32767, 0, 0, 0);
    push_sample(-32768, -32768, -32768, 0, 0, 0);
    push_sample(32767, -32768, 0, -1, 1, -1);
    push_sample(2048, 0, 0, 100, -100, 100);
    push_sample(-2049, 0, 0, 100, -100, 100);
    push_sample(0, 2047, 0, 0, 0, 0);
    push_sample(0, -2049, 0, 0, 0, 0);
    push_sample(0, 0, 3072, 0, 0, 0);
    push_sample(0, 0, -3071, 0, 0, 0);
    push_sample(0, 3073, 0, 0, 0, 0);
    push_sample(300, -400, 2500, 1234, -4321, 777);
    push_sample(-1200, 1200, -2400, -32768, 32767, 0);
    push_sample(1500, 1500, 1500, 2000, 2000, 2000);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      w = (p == 4) ? $urandom_range(131071) : phase_weight[p];
      load_gyro_weight(w);
      // The second phase runs with no idling on either side.
      in_idle_pct = (p == 1) ? 0 : 33;
      out_idle_pct = (p == 1) ? 0 : 33;
      queue_random_samples(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (attitude_due.size() != 0) begin
      errors++;
      $error("%0d result items never arrived", attitude_due.size());
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/acf_pkg.sv
src/acf_front.sv
src/acf_queue.sv
src/acf_axis.sv
src/acf_back.sv
src/imu_complementary_attitude_filter_unit.sv
test/imu_complementary_attitude_filter_unit_tb.sv
